>>> hdl/sorted_hash_set_index_unit_macros.svh
// Assertion macros for the sorted hash set index unit.
// Included by the modules that check themselves; needs i_clk and i_rst_n in scope.
`ifndef SORTED_HASH_SET_INDEX_UNIT_MACROS_SVH
`define SORTED_HASH_SET_INDEX_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// implication checked on every clock edge outside reset
`define SHS_ASSERT_IMPL(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("sorted hash set index: property failed");
// condition that must hold on every clock edge outside reset
`define SHS_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("sorted hash set index: invariant broken");
`else
`define SHS_ASSERT_IMPL(label, prop)
`define SHS_ASSERT_ALWAYS(label, expr)
`endif
`endif

>>> hdl/shs_idx_pkg.sv
// Package for the sorted hash set index unit: operation, mode and answer codes.
// No dependencies.
package shs_idx_pkg;
    localparam int MAX_HASHES_DEF = 1024;
    localparam int HASH_W         = 256;
    localparam int REV_W          = 63;
    localparam int COUNT_OUT_W    = 11;

    typedef logic [HASH_W-1:0] t_hash;

    // operation codes
    localparam logic [2:0] OP_QUERY      = 3'd0;
    localparam logic [2:0] OP_STAGE_ADD  = 3'd1;
    localparam logic [2:0] OP_STAGE_REM  = 3'd2;
    localparam logic [2:0] OP_COMMIT_RST = 3'd3;
    localparam logic [2:0] OP_COMMIT_DLT = 3'd4;
    localparam logic [2:0] OP_SET_SYNC   = 3'd5;
    localparam logic [2:0] OP_CLEAR      = 3'd6;

    // index modes
    localparam logic [1:0] MODE_NA    = 2'd0;
    localparam logic [1:0] MODE_SYNC  = 2'd1;
    localparam logic [1:0] MODE_READY = 2'd2;

    // query answers
    localparam logic [1:0] AV_NA      = 2'd0;
    localparam logic [1:0] AV_SYNC    = 2'd1;
    localparam logic [1:0] AV_ALL     = 2'd2;
    localparam logic [1:0] AV_SOME    = 2'd3;
endpackage

>>> hdl/sorted_hash_set_index_unit.sv
// Top level of the sorted hash set index unit: staging buffers, two-bank set
// memory, query search and commit sequencer. Depends on shs_idx_pkg and the macros header.
`include "sorted_hash_set_index_unit_macros.svh"
// Usage:
// An item is taken at a rising edge with start high and busy low. Its result
// appears on the o_ result ports for exactly one
// cycle, marked by o_valid; the receiver cannot stall, so every result must
// be taken in that cycle. index_mode, revision and entry_count show the state
// after the item.
// Staging, set syncing, clear, commits failing the up-front checks and queries
// in a mode other than ready or with i_hash_ok low are answered from idle.
// A ready query runs a binary search over the set memory, a read state and an
// evaluate state per step. A reset commit copies the incoming buffer record by record.
// A delta commit walks the two staging buffers, then merges the set with them
// into the other bank, a read state and an evaluate state per step.
// Every step waits on the registered read of the set and buffer memories.
// busy stays high while a search or commit runs; a new item may be taken in
// the cycle a result is shown.
// Reset: set empty, revision 0, mode not applicable, staging empty. The
// memories are not cleared; only entries below the counts are ever read.
module sorted_hash_set_index_unit #(
    parameter int MAX_HASHES = shs_idx_pkg::MAX_HASHES_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [2:0]                             i_operation,
    input  logic [63:0]                            i_hash_word3,
    input  logic [63:0]                            i_hash_word2,
    input  logic [63:0]                            i_hash_word1,
    input  logic [63:0]                            i_hash_word0,
    input  logic                                   i_hash_ok,
    input  logic signed [63:0]                     i_base_revision,
    input  logic signed [63:0]                     i_target_revision,
    output logic                                   o_valid,
    output logic                                   o_accepted,
    output logic [1:0]                             o_availability,
    output logic                                   o_changed,
    output logic [1:0]                             o_index_mode,
    output logic [shs_idx_pkg::REV_W-1:0]          o_revision,
    output logic [shs_idx_pkg::COUNT_OUT_W-1:0]    o_entry_count
);
    import shs_idx_pkg::*;

    localparam int CW  = $clog2(MAX_HASHES + 1);
    localparam int AW  = (MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1;
    localparam int SD  = 2 * MAX_HASHES;
    localparam int SAW = $clog2(SD);

    typedef enum logic [10:0] {
        S_IDLE = 11'b00000000001,
        S_QRD  = 11'b00000000010,
        S_QEX  = 11'b00000000100,
        S_CRD  = 11'b00000001000,
        S_CWR  = 11'b00000010000,
        S_DRD  = 11'b00000100000,
        S_DEX  = 11'b00001000000,
        S_MRD  = 11'b00010000000,
        S_MEX  = 11'b00100000000,
        S_TRD  = 11'b01000000000,
        S_TEX  = 11'b10000000000
    } t_state;

    function automatic logic [SAW-1:0] set_addr(input logic b, input logic [CW-1:0] c);
        set_addr = SAW'(c[AW-1:0]) + (b ? SAW'(MAX_HASHES) : SAW'(0));
    endfunction

    // memories
    t_hash set_mem [SD];
    t_hash inc_mem [MAX_HASHES];
    t_hash rem_mem [MAX_HASHES];

    t_state          r_state;
    logic            r_bank;
    logic [CW-1:0]   r_stored, r_ic, r_rc;
    logic            r_ifault, r_rfault;
    logic [1:0]      r_mode;
    logic [REV_W-1:0] r_rev, r_target;
    t_hash           r_inc_last, r_rem_last, r_hash;
    logic [CW-1:0]   r_i, r_a, r_r, r_n, r_lo, r_hi;
    logic            r_found;
    logic            r_valid, r_accepted, r_changed;
    logic [1:0]      r_avail;
    t_hash           set_q, inc_q, rem_q;

    t_hash           in_hash;
    logic            take;
    logic [CW-1:0]   mid;
    logic            stage_ok_i, stage_ok_r;
    logic            rst_ok, dlt_ok;
    logic            set_we, inc_we, rem_we;
    logic [SAW-1:0]  set_waddr, set_raddr;
    t_hash           set_wdata;
    logic [AW-1:0]   inc_raddr, rem_raddr;
    logic            m_rem_live, m_add_live, m_full;
    logic            m_rem_lt, m_rem_eq, m_add_lt, m_add_eq;

    assign in_hash = {i_hash_word3, i_hash_word2, i_hash_word1, i_hash_word0};
    assign take    = start && (r_state == S_IDLE);
    assign busy    = (r_state != S_IDLE);
    assign mid     = r_lo + ((r_hi - r_lo) >> 1);

    // staging checks against the last record of each buffer
    assign stage_ok_i = (r_ic < CW'(MAX_HASHES)) && ((r_ic == '0) || (r_inc_last < in_hash));
    assign stage_ok_r = (r_rc < CW'(MAX_HASHES)) && ((r_rc == '0) || (r_rem_last < in_hash));

    // commit pre-checks
    assign rst_ok = (i_target_revision != 64'sd0) && !i_target_revision[63]
                    && (i_target_revision[REV_W-1:0] >= r_rev) && !r_ifault;
    assign dlt_ok = (r_mode == MODE_READY) && (i_base_revision == {1'b0, r_rev})
                    && !i_target_revision[63]
                    && ({1'b0, r_rev} < i_target_revision)
                    && !r_ifault && !r_rfault
                    && (({1'b0, r_ic} + {1'b0, r_rc}) <= (CW+1)'(MAX_HASHES));

    // merge step decisions
    assign m_rem_live = (r_r < r_rc);
    assign m_add_live = (r_a < r_ic);
    assign m_full     = (r_n >= CW'(MAX_HASHES));
    assign m_rem_lt   = m_rem_live && (rem_q < set_q);
    assign m_rem_eq   = m_rem_live && (rem_q == set_q);
    assign m_add_lt   = m_add_live && (inc_q < set_q);
    assign m_add_eq   = m_add_live && (inc_q == set_q);

    // memory addressing and write strobes
    always_comb begin
        set_we    = 1'b0;
        set_waddr = set_addr(!r_bank, r_n);
        set_wdata = inc_q;
        set_raddr = set_addr(r_bank, r_i);
        inc_raddr = r_a[AW-1:0];
        rem_raddr = r_r[AW-1:0];
        inc_we    = take && (i_operation == OP_STAGE_ADD) && !r_ifault && stage_ok_i;
        rem_we    = take && (i_operation == OP_STAGE_REM) && !r_rfault && stage_ok_r;
        case (r_state)
            S_QRD: begin
                set_raddr = set_addr(r_bank, mid);
            end
            S_CRD: begin
                inc_raddr = r_i[AW-1:0];
            end
            S_CWR: begin
                set_we    = 1'b1;
                set_waddr = set_addr(!r_bank, r_i);
            end
            S_MEX: begin
                if (!m_rem_lt && !m_rem_eq && !m_add_eq && !m_full) begin
                    set_we    = 1'b1;
                    set_wdata = m_add_lt ? inc_q : set_q;
                end
            end
            S_TEX: begin
                set_we = !m_full;
            end
            default: begin
            end
        endcase
    end

    // set memory, both banks
    always_ff @(posedge i_clk) begin
        if (set_we) begin
            set_mem[set_waddr] <= set_wdata;
        end
        set_q <= set_mem[set_raddr];
    end

    // incoming staging buffer
    always_ff @(posedge i_clk) begin
        if (inc_we) begin
            inc_mem[r_ic[AW-1:0]] <= in_hash;
        end
        inc_q <= inc_mem[inc_raddr];
    end

    // removal staging buffer
    always_ff @(posedge i_clk) begin
        if (rem_we) begin
            rem_mem[r_rc[AW-1:0]] <= in_hash;
        end
        rem_q <= rem_mem[rem_raddr];
    end

    // payload captured with the beat
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_hash   <= in_hash;
            r_target <= i_target_revision[REV_W-1:0];
        end
        if (inc_we) begin
            r_inc_last <= in_hash;
        end
        if (rem_we) begin
            r_rem_last <= in_hash;
        end
    end

    // sequencer and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_bank     <= 1'b0;
            r_stored   <= '0;
            r_ic       <= '0;
            r_rc       <= '0;
            r_ifault   <= 1'b0;
            r_rfault   <= 1'b0;
            r_mode     <= MODE_NA;
            r_rev      <= '0;
            r_i        <= '0;
            r_a        <= '0;
            r_r        <= '0;
            r_n        <= '0;
            r_lo       <= '0;
            r_hi       <= '0;
            r_found    <= 1'b0;
            r_valid    <= 1'b0;
            r_accepted <= 1'b0;
            r_changed  <= 1'b0;
            r_avail    <= AV_NA;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        case (i_operation)
                            OP_QUERY: begin
                                r_accepted <= 1'b1;
                                r_changed  <= 1'b0;
                                if ((r_mode == MODE_READY) && i_hash_ok) begin
                                    // search instead of answering now
                                    r_valid <= 1'b0;
                                    r_avail <= AV_NA;
                                    r_lo    <= '0;
                                    r_hi    <= r_stored;
                                    r_found <= 1'b0;
                                    r_state <= S_QRD;
                                end else begin
                                    r_valid <= 1'b1;
                                    if (r_mode == MODE_NA) begin
                                        r_avail <= AV_NA;
                                    end else if (r_mode == MODE_SYNC) begin
                                        r_avail <= AV_SYNC;
                                    end else begin
                                        r_avail <= AV_SOME;
                                    end
                                end
                            end
                            OP_STAGE_ADD: begin
                                r_valid    <= 1'b1;
                                r_changed  <= 1'b0;
                                r_avail    <= AV_NA;
                                r_accepted <= !r_ifault && stage_ok_i;
                                if (!r_ifault) begin
                                    if (stage_ok_i) begin
                                        r_ic <= r_ic + CW'(1);
                                    end else begin
                                        r_ifault <= 1'b1;
                                    end
                                end
                            end
                            OP_STAGE_REM: begin
                                r_valid    <= 1'b1;
                                r_changed  <= 1'b0;
                                r_avail    <= AV_NA;
                                r_accepted <= !r_rfault && stage_ok_r;
                                if (!r_rfault) begin
                                    if (stage_ok_r) begin
                                        r_rc <= r_rc + CW'(1);
                                    end else begin
                                        r_rfault <= 1'b1;
                                    end
                                end
                            end
                            OP_COMMIT_RST: begin
                                r_accepted <= 1'b0;
                                r_changed  <= 1'b0;
                                r_avail    <= AV_NA;
                                r_valid    <= !rst_ok;
                                if (rst_ok) begin
                                    r_i     <= '0;
                                    r_state <= S_CRD;
                                end else begin
                                    r_ic     <= '0;
                                    r_rc     <= '0;
                                    r_ifault <= 1'b0;
                                    r_rfault <= 1'b0;
                                end
                            end
                            OP_COMMIT_DLT: begin
                                r_accepted <= 1'b0;
                                r_changed  <= 1'b0;
                                r_avail    <= AV_NA;
                                r_valid    <= !dlt_ok;
                                if (dlt_ok) begin
                                    r_a     <= '0;
                                    r_r     <= '0;
                                    r_state <= S_DRD;
                                end else begin
                                    r_ic     <= '0;
                                    r_rc     <= '0;
                                    r_ifault <= 1'b0;
                                    r_rfault <= 1'b0;
                                end
                            end
                            OP_SET_SYNC: begin
                                r_valid    <= 1'b1;
                                r_avail    <= AV_NA;
                                r_accepted <= 1'b1;
                                r_changed  <= (r_mode != MODE_SYNC);
                                r_mode     <= MODE_SYNC;
                            end
                            OP_CLEAR: begin
                                r_valid    <= 1'b1;
                                r_avail    <= AV_NA;
                                r_accepted <= 1'b1;
                                r_changed  <= !((r_mode == MODE_NA) && (r_rev == '0)
                                                && (r_stored == '0));
                                r_mode     <= MODE_NA;
                                r_rev      <= '0;
                                r_stored   <= '0;
                            end
                            default: begin
                                r_valid    <= 1'b1;
                                r_avail    <= AV_NA;
                                r_accepted <= 1'b0;
                                r_changed  <= 1'b0;
                            end
                        endcase
                    end else begin
                        r_valid <= 1'b0;
                    end
                end
                // binary search: issue the read at mid, then narrow
                S_QRD: begin
                    if (r_lo < r_hi) begin
                        r_valid <= 1'b0;
                        r_state <= S_QEX;
                    end else begin
                        r_avail <= r_found ? AV_ALL : AV_SOME;
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_QEX: begin
                    r_valid <= 1'b0;
                    if (set_q < r_hash) begin
                        r_lo <= mid + CW'(1);
                    end else begin
                        r_hi <= mid;
                    end
                    if (set_q == r_hash) begin
                        r_found <= 1'b1;
                    end
                    r_state <= S_QRD;
                end
                // reset commit: copy the incoming buffer to the idle bank
                S_CRD: begin
                    if (r_i < r_ic) begin
                        r_valid <= 1'b0;
                        r_state <= S_CWR;
                    end else begin
                        r_bank     <= !r_bank;
                        r_stored   <= r_ic;
                        r_rev      <= r_target;
                        r_mode     <= MODE_READY;
                        r_accepted <= 1'b1;
                        r_changed  <= 1'b1;
                        r_ic       <= '0;
                        r_rc       <= '0;
                        r_ifault   <= 1'b0;
                        r_rfault   <= 1'b0;
                        r_valid    <= 1'b1;
                        r_state    <= S_IDLE;
                    end
                end
                S_CWR: begin
                    r_valid <= 1'b0;
                    r_i     <= r_i + CW'(1);
                    r_state <= S_CRD;
                end
                // disjointness walk over both staging buffers
                S_DRD: begin
                    r_valid <= 1'b0;
                    if ((r_a < r_ic) && (r_r < r_rc)) begin
                        r_state <= S_DEX;
                    end else begin
                        r_i     <= '0;
                        r_a     <= '0;
                        r_r     <= '0;
                        r_n     <= '0;
                        r_state <= S_MRD;
                    end
                end
                S_DEX: begin
                    if (inc_q == rem_q) begin
                        r_ic     <= '0;
                        r_rc     <= '0;
                        r_ifault <= 1'b0;
                        r_rfault <= 1'b0;
                        r_valid  <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_valid <= 1'b0;
                        if (inc_q < rem_q) begin
                            r_a <= r_a + CW'(1);
                        end else begin
                            r_r <= r_r + CW'(1);
                        end
                        r_state <= S_DRD;
                    end
                end
                // merge: set minus removals plus adds into the idle bank
                S_MRD: begin
                    if (r_i < r_stored) begin
                        r_valid <= 1'b0;
                        r_state <= S_MEX;
                    end else if (r_r != r_rc) begin
                        r_ic     <= '0;
                        r_rc     <= '0;
                        r_ifault <= 1'b0;
                        r_rfault <= 1'b0;
                        r_valid  <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_valid <= 1'b0;
                        r_state <= S_TRD;
                    end
                end
                S_MEX: begin
                    if (m_rem_eq) begin
                        r_valid <= 1'b0;
                        r_r     <= r_r + CW'(1);
                        r_i     <= r_i + CW'(1);
                        r_state <= S_MRD;
                    end else if (m_rem_lt || m_add_eq || m_full) begin
                        r_ic     <= '0;
                        r_rc     <= '0;
                        r_ifault <= 1'b0;
                        r_rfault <= 1'b0;
                        r_valid  <= 1'b1;
                        r_state  <= S_IDLE;
                    end else if (m_add_lt) begin
                        r_valid <= 1'b0;
                        r_n     <= r_n + CW'(1);
                        r_a     <= r_a + CW'(1);
                        r_state <= S_MRD;
                    end else begin
                        r_valid <= 1'b0;
                        r_n     <= r_n + CW'(1);
                        r_i     <= r_i + CW'(1);
                        r_state <= S_MRD;
                    end
                end
                // tail: append the remaining adds
                S_TRD: begin
                    if (r_a < r_ic) begin
                        r_valid <= 1'b0;
                        r_state <= S_TEX;
                    end else begin
                        r_bank     <= !r_bank;
                        r_stored   <= r_n;
                        r_rev      <= r_target;
                        r_accepted <= 1'b1;
                        r_changed  <= 1'b1;
                        r_ic       <= '0;
                        r_rc       <= '0;
                        r_ifault   <= 1'b0;
                        r_rfault   <= 1'b0;
                        r_valid    <= 1'b1;
                        r_state    <= S_IDLE;
                    end
                end
                S_TEX: begin
                    if (m_full) begin
                        r_ic     <= '0;
                        r_rc     <= '0;
                        r_ifault <= 1'b0;
                        r_rfault <= 1'b0;
                        r_valid  <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_valid <= 1'b0;
                        r_n     <= r_n + CW'(1);
                        r_a     <= r_a + CW'(1);
                        r_state <= S_TRD;
                    end
                end
                default: begin
                    r_valid <= 1'b0;
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid        = r_valid;
    assign o_accepted     = r_accepted;
    assign o_availability = r_avail;
    assign o_changed      = r_changed;
    assign o_index_mode   = r_mode;
    assign o_revision     = r_rev;
    assign o_entry_count  = COUNT_OUT_W'(r_stored);

    // a taken beat either answers next cycle or keeps the unit busy
    `SHS_ASSERT_IMPL(a_take_progress, (start && !busy) |=> (o_valid || busy))
    // the set never holds more than its limit
    `SHS_ASSERT_ALWAYS(a_count_limit, r_stored <= CW'(MAX_HASHES))
    // merge writes stay inside the destination bank
    `SHS_ASSERT_IMPL(a_merge_bound,
        (set_we && (r_state == S_MEX || r_state == S_TEX)) |-> (r_n < CW'(MAX_HASHES)))
    // staging counts stay within their buffers
    `SHS_ASSERT_ALWAYS(a_stage_limit,
        (r_ic <= CW'(MAX_HASHES)) && (r_rc <= CW'(MAX_HASHES)))
endmodule
